// ===== hdl/rtcc_pkg.sv =====
// Package for the rank to Cartesian coordinates block.
// Holds field widths, register indexes, status codes and the result type.
// Depends on nothing.
package rtcc_pkg;

  localparam int unsigned CFG_W     = 17;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned AXIS_W    = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned REG_IDX_W = 3;

  typedef logic [CFG_W-1:0] cfg_word_t;

  localparam logic [REG_IDX_W-1:0] REG_NUM_DIMS    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GROUP_SIZE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXTENT_BASE = 3'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANK  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_COUNT = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0]  coordinate;
    logic [AXIS_W-1:0]   axis;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

endpackage

// ===== hdl/rtcc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Stand-alone; the width is set by the DW parameter.
module rtcc_div #(
  parameter int unsigned DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [DW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [DW:0]   shifted;
  logic [DW:0]   trial;

  assign shifted = {rem, quo[DW-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DW);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[DW]) begin
        rem <= trial[DW-1:0];
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= shifted[DW-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== hdl/rtcc_cfg.sv =====
// Configuration registers: dimension count, group size and the extents.
// Depends on rtcc_pkg for widths and register indexes.
module rtcc_cfg
  import rtcc_pkg::*;
#(
  parameter int unsigned MAX_DIMS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [REG_IDX_W-1:0]          wr_index,
  input  cfg_word_t                     wr_data,
  output logic [AXIS_W-1:0]             num_dims,
  output cfg_word_t                     group_size,
  output logic [MAX_DIMS-1:0][CFG_W-1:0] extent
);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims   <= AXIS_W'(1);
      group_size <= CFG_W'(1);
      for (int i = 0; i < MAX_DIMS; i++) begin
        extent[i] <= CFG_W'(1);
      end
    end else if (wr_en) begin
      if (wr_index == REG_NUM_DIMS) begin
        num_dims <= wr_data[AXIS_W-1:0];
      end
      if (wr_index == REG_GROUP_SIZE) begin
        group_size <= wr_data;
      end
      for (int i = 0; i < MAX_DIMS; i++) begin
        if (wr_index == REG_EXTENT_BASE + REG_IDX_W'(i)) begin
          extent[i] <= wr_data;
        end
      end
    end
  end

endmodule

// ===== hdl/rank_to_cartesian_coords.sv =====
// Top level: turns a linear rank into row-major grid coordinates.
// Depends on rtcc_pkg, rtcc_cfg and rtcc_div.
//
// Channel   Handshake            Fields
// rank      rank_valid/stall     proc_rank, max_coords
// coord     coord_valid/stall    coordinate, axis, status, last
// cfg       cfg_valid/ready      cfg_index, cfg_data
//
// Each dimension takes two passes of the bit-serial divider, whose width DW is
// the larger of RANK_WIDTH and 17, sequenced by the S_NEXT and S_EMIT states.
// A dimension whose factor runs out to zero skips the second pass.
// An error request goes straight to S_EMIT. One request is worked on at a time.
// A stalled result waits in the output register; the sequencer holds its
// next result until that register is free. Reset sets every config register to one.
module rank_to_cartesian_coords
  import rtcc_pkg::*;
#(
  parameter int unsigned MAX_DIMS   = 6,
  parameter int unsigned RANK_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rank_valid,
  output logic                  rank_stall,
  input  logic [RANK_WIDTH-1:0] proc_rank,
  input  logic [AXIS_W-1:0]     max_coords,
  output logic                  coord_valid,
  input  logic                  coord_stall,
  output logic [COORD_W-1:0]    coordinate,
  output logic [AXIS_W-1:0]     axis,
  output logic [STATUS_W-1:0]   status,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  cfg_word_t             cfg_data
);

  localparam int unsigned DW = (RANK_WIDTH > CFG_W) ? RANK_WIDTH : CFG_W;
  localparam int unsigned IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NEXT = 3'd1;
  localparam logic [2:0] S_DIVF = 3'd2;
  localparam logic [2:0] S_DIVR = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]                    state;
  logic [RANK_WIDTH-1:0]         rank;
  cfg_word_t                     factor;
  logic [AXIS_W-1:0]             dim;
  result_t                       pend;
  result_t                       out_reg;

  logic [AXIS_W-1:0]             num_dims;
  cfg_word_t                     group_size;
  logic [MAX_DIMS-1:0][CFG_W-1:0] extent;
  logic [AXIS_W-1:0]             n_eff;
  cfg_word_t                     ext_cur;
  logic                          last_dim;
  logic                          out_free;

  logic                          div_start;
  logic                          div_done;
  logic [DW-1:0]                 div_dividend;
  logic [DW-1:0]                 div_divisor;
  logic [DW-1:0]                 div_quo;
  logic [DW-1:0]                 div_rem;

  rtcc_cfg #(
    .MAX_DIMS(MAX_DIMS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cfg_valid & cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .num_dims  (num_dims),
    .group_size(group_size),
    .extent    (extent)
  );

  rtcc_div #(
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  assign cfg_ready  = 1'b1;
  assign rank_stall = (state != S_IDLE);
  assign out_free   = !coord_valid || !coord_stall;

  always_comb begin
    if (num_dims == '0) begin
      n_eff = AXIS_W'(1);
    end else if (num_dims > AXIS_W'(MAX_DIMS)) begin
      n_eff = AXIS_W'(MAX_DIMS);
    end else begin
      n_eff = num_dims;
    end
  end

  assign ext_cur  = (extent[dim[IW-1:0]] == '0) ? CFG_W'(1) : extent[dim[IW-1:0]];
  assign last_dim = (dim == n_eff - AXIS_W'(1));

  assign div_start = (state == S_NEXT) ||
                     ((state == S_DIVF) && div_done && (div_quo != '0));
  assign div_dividend = (state == S_NEXT) ? DW'(factor) : DW'(rank);
  assign div_divisor  = (state == S_NEXT) ? DW'(ext_cur) : div_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      coord_valid <= 1'b0;
    end else begin
      if ((state == S_EMIT) && out_free) begin
        coord_valid <= 1'b1;
      end else if (coord_valid && !coord_stall) begin
        coord_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (rank_valid) begin
            if (max_coords == '0 || DW'(proc_rank) >= DW'(group_size)) begin
              state <= S_EMIT;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          state <= S_DIVF;
        end
        S_DIVF: begin
          if (div_done) begin
            state <= (div_quo == '0) ? S_EMIT : S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= pend.last ? S_IDLE : S_NEXT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rank   <= proc_rank;
        factor <= group_size;
        dim    <= '0;
        pend.coordinate <= '0;
        pend.axis       <= '0;
        pend.last       <= 1'b1;
        if (max_coords == '0) begin
          pend.status <= STATUS_COUNT;
        end else begin
          pend.status <= STATUS_RANK;
        end
      end
      S_DIVF: begin
        if (div_done) begin
          factor          <= div_quo[CFG_W-1:0];
          pend.coordinate <= '0;
          pend.axis       <= dim;
          pend.status     <= STATUS_OK;
          pend.last       <= last_dim;
        end
      end
      S_DIVR: begin
        if (div_done) begin
          rank            <= div_rem[RANK_WIDTH-1:0];
          pend.coordinate <= div_quo[COORD_W-1:0];
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_reg <= pend;
          if (!pend.last) begin
            dim <= dim + AXIS_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign coordinate = out_reg.coordinate;
  assign axis       = out_reg.axis;
  assign status     = out_reg.status;
  assign last       = out_reg.last;

endmodule

// ===== sim/rtcc_checker.sv =====
`timescale 1ns / 100ps
// Checker for rank_to_cartesian_coords: watches the rank, coord and cfg channels,
// predicts each request's coordinates from its own copy of the registers and compares.
// Depends on rtcc_pkg.
module rtcc_checker
  import rtcc_pkg::*;
#(
  parameter int unsigned MAX_DIMS   = 6,
  parameter int unsigned RANK_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rank_valid,
  input  logic                  rank_stall,
  input  logic [RANK_WIDTH-1:0] proc_rank,
  input  logic [AXIS_W-1:0]     max_coords,
  input  logic                  coord_valid,
  input  logic                  coord_stall,
  input  logic [COORD_W-1:0]    coordinate,
  input  logic [AXIS_W-1:0]     axis,
  input  logic [STATUS_W-1:0]   status,
  input  logic                  last,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  cfg_word_t             cfg_data,
  output int unsigned           error_count,
  output int unsigned           coords_owed
);

  localparam int unsigned NUM_EXTENTS = 6;

  logic [2:0] dims_reg;
  cfg_word_t  group_reg;
  cfg_word_t  extent_reg [NUM_EXTENTS];
  result_t    coords_due [$];

  function automatic void predict_coords(input logic [RANK_WIDTH-1:0] rank_in,
                                         input logic [AXIS_W-1:0] capacity);
    result_t     res;
    int unsigned remainder;
    int unsigned factor;
    int unsigned ext;
    int unsigned dims;
    int unsigned coord;
    int unsigned d;
    res = '0;
    res.last = 1'b1;
    remainder = 32'(rank_in);
    factor = 32'(group_reg);
    if (capacity == '0) begin
      res.status = STATUS_COUNT;
      coords_due.push_back(res);
      return;
    end
    if (remainder >= factor) begin
      res.status = STATUS_RANK;
      coords_due.push_back(res);
      return;
    end
    dims = 32'(dims_reg);
    if (dims < 1) dims = 1;
    if (dims > MAX_DIMS) dims = MAX_DIMS;
    for (d = 0; d < dims; d++) begin
      ext = 32'(extent_reg[3'(d)]);
      if (ext == 0) ext = 1;
      factor = factor / ext;
      if (factor == 0) begin
        coord = 0;
      end else begin
        coord = remainder / factor;
        remainder = remainder % factor;
      end
      res.coordinate = COORD_W'(coord);
      res.axis = AXIS_W'(d);
      res.status = STATUS_OK;
      res.last = (d + 1 == dims);
      coords_due.push_back(res);
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    int i;
    if (rst) begin
      dims_reg = 3'd1;
      group_reg = CFG_W'(1);
      for (i = 0; i < NUM_EXTENTS; i++) extent_reg[3'(i)] = CFG_W'(1);
      coords_due.delete();
      error_count = 0;
    end else begin
      if (coord_valid === 1'b1 && coord_stall == 1'b0) begin
        if (coords_due.size() == 0) begin
          $error("unrequested result: coordinate %0d axis %0d status %0d last %0d",
                 coordinate, axis, status, last);
          error_count++;
        end else begin
          want = coords_due.pop_front();
          check_field("coordinate", 32'(want.coordinate), 32'(coordinate));
          check_field("axis", 32'(want.axis), 32'(axis));
          check_field("status", 32'(want.status), 32'(status));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
      if (rank_valid && rank_stall === 1'b0) predict_coords(proc_rank, max_coords);
      if (cfg_valid && cfg_ready === 1'b1) begin
        case (cfg_index)
          REG_NUM_DIMS: begin
            dims_reg = cfg_data[2:0];
          end
          REG_GROUP_SIZE: begin
            group_reg = cfg_data;
          end
          default: begin
            extent_reg[cfg_index - REG_EXTENT_BASE] = cfg_data;
          end
        endcase
      end
    end
    coords_owed = coords_due.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the rank_to_cartesian_coords testbench: clock, reset, grid settings, rank
// requests and result back-pressure; the verdict comes from rtcc_checker.
// Depends on rtcc_pkg, rtcc_checker and the block itself.
module tb_top
  import rtcc_pkg::*;
;

  logic                 clk;
  logic                 rst;
  logic                 rank_valid;
  logic                 rank_stall;
  logic [15:0]          proc_rank;
  logic [AXIS_W-1:0]    max_coords;
  logic                 coord_valid;
  logic                 coord_stall;
  logic [COORD_W-1:0]   coordinate;
  logic [AXIS_W-1:0]    axis;
  logic [STATUS_W-1:0]  status;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  cfg_word_t            cfg_data;
  int unsigned          error_count;
  int unsigned          coords_owed;
  int unsigned          coords_taken;
  cfg_word_t            grid_extent [6];

  rank_to_cartesian_coords i_dut (
    .clk         (clk),
    .rst         (rst),
    .rank_valid  (rank_valid),
    .rank_stall  (rank_stall),
    .proc_rank   (proc_rank),
    .max_coords  (max_coords),
    .coord_valid (coord_valid),
    .coord_stall (coord_stall),
    .coordinate  (coordinate),
    .axis        (axis),
    .status      (status),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  rtcc_checker i_check (
    .clk         (clk),
    .rst         (rst),
    .rank_valid  (rank_valid),
    .rank_stall  (rank_stall),
    .proc_rank   (proc_rank),
    .max_coords  (max_coords),
    .coord_valid (coord_valid),
    .coord_stall (coord_stall),
    .coordinate  (coordinate),
    .axis        (axis),
    .status      (status),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .coords_owed (coords_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      coords_taken <= 0;
    end else if (coord_valid && !coord_stall) begin
      coords_taken <= coords_taken + 1;
    end
  end

  // Result back-pressure in segments of differing density, with one long hold-off
  // once traffic is well under way so that the block backs up onto its input.
  initial begin
    int unsigned seg;
    int unsigned mode;
    int unsigned hold;
    bit          held;
    coord_stall = 1'b0;
    hold = 0;
    held = 1'b0;
    forever begin
      seg = $urandom_range(8, 80);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(negedge clk);
        if (!held && coords_taken >= 200) begin
          held = 1'b1;
          hold = 800;
        end
        if (hold != 0) begin
          coord_stall <= 1'b1;
          hold--;
        end else begin
          case (mode)
            0: coord_stall <= 1'b0;
            1: coord_stall <= ($urandom_range(0, 3) == 0);
            2: coord_stall <= ($urandom_range(0, 9) < 7);
            default: coord_stall <= ~coord_stall;
          endcase
        end
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] index, input cfg_word_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_grid(input logic [2:0] dims, input cfg_word_t group);
    int d;
    write_reg(REG_NUM_DIMS, CFG_W'(dims));
    write_reg(REG_GROUP_SIZE, group);
    for (d = 0; d < 6; d++) write_reg(REG_EXTENT_BASE + REG_IDX_W'(d), grid_extent[3'(d)]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic offer_rank(input logic [15:0] rank_in, input logic [AXIS_W-1:0] capacity);
    @(negedge clk);
    rank_valid <= 1'b1;
    proc_rank <= rank_in;
    max_coords <= capacity;
    @(posedge clk);
    while (rank_stall) @(posedge clk);
  endtask

  task automatic drain_requests();
    @(negedge clk);
    rank_valid <= 1'b0;
    while (coords_owed != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned phase;
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned dims;
    int unsigned prod;
    int unsigned lim;
    int unsigned top_e;
    int unsigned d;
    int unsigned group;
    logic [2:0]  dims_code;
    logic [15:0] rank_pick;
    logic [2:0]  cap_pick;
    rst = 1'b1;
    rank_valid = 1'b0;
    proc_rank = '0;
    max_coords = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers at their reset values: a one-point grid.
    offer_rank(16'd0, 3'd1);
    offer_rank(16'd1, 3'd3);
    offer_rank(16'hFFFF, 3'd0);
    drain_requests();

    // Full six-dimensional grid of 65536 ranks, including a small capacity.
    grid_extent = '{17'd4, 17'd4, 17'd8, 17'd16, 17'd4, 17'd8};
    load_grid(3'd6, 17'd65536);
    offer_rank(16'hFFFF, 3'd6);
    offer_rank(16'h0000, 3'd7);
    offer_rank(16'hAAAA, 3'd1);
    offer_rank(16'h5555, 3'd2);
    offer_rank(16'd12345, 3'd4);
    offer_rank(16'h8000, 3'd0);
    drain_requests();

    // Dimension count above range, a zero extent and a factor that runs out.
    grid_extent = '{17'd3, 17'd0, 17'd7, 17'd5, 17'd2, 17'h10000};
    load_grid(3'd7, 17'd100);
    offer_rank(16'd99, 3'd5);
    offer_rank(16'd100, 3'd5);
    offer_rank(16'd57, 3'd3);
    drain_requests();

    // Dimension count of zero with the largest group size.
    grid_extent = '{17'h1FFFF, 17'h10000, 17'h10000, 17'h10000, 17'h10000, 17'h10000};
    load_grid(3'd0, 17'h1FFFF);
    offer_rank(16'hFFFF, 3'd1);
    offer_rank(16'd0, 3'd6);
    drain_requests();

    // Empty group: every rank is out of range, but a bad count still wins.
    grid_extent = '{17'd2, 17'd2, 17'd2, 17'd1, 17'd1, 17'd1};
    load_grid(3'd3, 17'd0);
    offer_rank(16'd0, 3'd1);
    offer_rank(16'hFFFF, 3'd0);
    drain_requests();

    grid_extent = '{17'h10000, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1};
    load_grid(3'd2, 17'd65536);
    offer_rank(16'd40000, 3'd2);
    offer_rank(16'd1, 3'd1);
    drain_requests();

    for (phase = 0; phase < 6; phase++) begin
      dims_code = 3'($urandom_range(1, 6));
      if ($urandom_range(0, 9) == 0) dims_code = $urandom_range(0, 1) ? 3'd7 : 3'd0;
      dims = (dims_code == 0) ? 1 : (dims_code > 6) ? 6 : dims_code;
      prod = 1;
      for (d = 0; d < 6; d++) begin
        lim = 65536 / prod;
        top_e = 1 << $urandom_range(0, 5);
        if (top_e > lim) top_e = lim;
        grid_extent[3'(d)] = CFG_W'($urandom_range(1, top_e));
        if (d < dims) prod = prod * grid_extent[3'(d)];
        else if ($urandom_range(0, 1) == 1) grid_extent[3'(d)] = CFG_W'($urandom_range(0, 131071));
      end
      if ($urandom_range(0, 9) == 0) grid_extent[3'($urandom_range(0, dims - 1))] = '0;
      group = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071) : prod;
      load_grid(dims_code, CFG_W'(group));
      lim = (group > 65536) ? 65536 : group;

      sent = 0;
      while (sent < 50) begin
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          if (sent < 50) begin
            if (group != 0 && $urandom_range(0, 99) < 85) begin
              rank_pick = 16'($urandom_range(0, lim - 1));
            end else begin
              rank_pick = 16'($urandom_range(0, 65535));
            end
            cap_pick = ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
            offer_rank(rank_pick, cap_pick);
            sent++;
          end
        end
        if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 300);
        else gap = $urandom_range(0, 12);
        if (gap != 0) begin
          @(negedge clk);
          rank_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      drain_requests();
    end

    repeat (250) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rtcc_pkg.sv
hdl/rtcc_div.sv
hdl/rtcc_cfg.sv
hdl/rank_to_cartesian_coords.sv
sim/rtcc_checker.sv
sim/tb_top.sv
